// ===== rtl/ttmg_pkg.sv =====
// ============================================================================
// ttmg_pkg
// Shared constants and types for the two-trade maximum gain block.
// ============================================================================
package ttmg_pkg;

    localparam int SERIES_DEPTH = 1024;
    localparam int PRICE_W      = 16;
    localparam int GAIN_W       = PRICE_W + 1;
    localparam int ADDR_W       = $clog2(SERIES_DEPTH);
    localparam int CNT_W        = $clog2(SERIES_DEPTH + 1);
    localparam int ENTRY_W      = 2 * PRICE_W;
    localparam int IN_DATA_W    = 16;
    localparam int OUT_DATA_W   = 24;

    typedef logic [PRICE_W-1:0] price_t;
    typedef logic [GAIN_W-1:0]  gain_t;
    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [CNT_W-1:0]   count_t;
    typedef logic [ENTRY_W-1:0] entry_t;

    // Store write port request
    typedef struct packed {
        logic   en;
        addr_t  addr;
        entry_t data;
    } mem_wr_t;

    // Store read port request
    typedef struct packed {
        logic  en;
        addr_t addr;
    } mem_rd_t;

endpackage

// ===== rtl/ttmg_ram.sv =====
// ============================================================================
// ttmg_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ============================================================================
module ttmg_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 10
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [0:(1 << ADDR_W)-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/ttmg_core.sv =====
// ============================================================================
// ttmg_core
// Load sequencer with running minimum, backward walk with running maximum,
// and the result register.
// ============================================================================
module ttmg_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [ttmg_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [ttmg_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tuser,
    output ttmg_pkg::mem_wr_t                  mem_wr,
    output ttmg_pkg::mem_rd_t                  mem_rd,
    input  ttmg_pkg::entry_t                   mem_rdata
);

    import ttmg_pkg::*;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_WALK,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    count_t count_reg, count_next;
    logic   dropped_reg, dropped_next;
    price_t low_reg, low_next;
    price_t prefix_reg, prefix_next;
    price_t high_reg, high_next;
    price_t suffix_reg, suffix_next;
    gain_t  total_reg, total_next;
    addr_t  rd_addr_reg, rd_addr_next;
    logic   rd_pend_reg, rd_pend_next;
    logic   out_valid_reg, out_valid_next;
    gain_t  out_gain_reg, out_gain_next;
    logic   out_flag_reg, out_flag_next;

    logic   in_fire;
    logic   full;
    price_t ld_price;
    price_t ld_diff;
    price_t ld_gain;
    count_t cnt_dec;
    price_t wk_price;
    price_t wk_prefix;
    price_t wk_diff;
    price_t wk_suffix;
    gain_t  wk_sum;
    logic   out_free;

    assign s_axis_tready = (state_reg == ST_LOAD);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign full          = (count_reg == CNT_W'(SERIES_DEPTH));
    assign out_free      = !out_valid_reg || m_axis_tready;

    // Prefix gain for the incoming price
    assign ld_price = s_axis_tdata[PRICE_W-1:0];
    assign ld_diff  = ld_price - low_reg;
    always_comb
    begin
        if (count_reg == '0)
            ld_gain = '0;
        else if ((ld_price > low_reg) && (ld_diff > prefix_reg))
            ld_gain = ld_diff;
        else
            ld_gain = prefix_reg;
    end

    assign mem_wr.en   = in_fire && !full;
    assign mem_wr.addr = count_reg[ADDR_W-1:0];
    assign mem_wr.data = {ld_gain, ld_price};

    assign cnt_dec = count_reg - CNT_W'(1);

    // Suffix gain and two-trade sum for the entry just read back
    assign wk_price  = mem_rdata[PRICE_W-1:0];
    assign wk_prefix = mem_rdata[ENTRY_W-1:PRICE_W];
    assign wk_diff   = high_reg - wk_price;
    assign wk_suffix = ((high_reg > wk_price) && (wk_diff > suffix_reg)) ? wk_diff : suffix_reg;
    assign wk_sum    = GAIN_W'(wk_prefix) + GAIN_W'(wk_suffix);

    assign mem_rd.en   = (state_reg == ST_WALK);
    assign mem_rd.addr = rd_addr_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        low_next       = low_reg;
        prefix_next    = prefix_reg;
        high_next      = high_reg;
        suffix_next    = suffix_reg;
        total_next     = total_reg;
        rd_addr_next   = rd_addr_reg;
        rd_pend_next   = 1'b0;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_gain_next  = out_gain_reg;
        out_flag_next  = out_flag_reg;

        if (rd_pend_reg)
        begin
            suffix_next = wk_suffix;
            high_next   = (wk_price > high_reg) ? wk_price : high_reg;
            total_next  = (wk_sum > total_reg) ? wk_sum : total_reg;
        end

        case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    if (full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        count_next  = count_reg + CNT_W'(1);
                        prefix_next = ld_gain;
                        if ((count_reg == '0) || (ld_price < low_reg))
                            low_next = ld_price;
                    end
                    if (s_axis_tlast)
                    begin
                        // Start the walk at the newest stored entry
                        rd_addr_next = full ? cnt_dec[ADDR_W-1:0] : count_reg[ADDR_W-1:0];
                        high_next    = '0;
                        suffix_next  = '0;
                        total_next   = '0;
                        state_next   = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                rd_pend_next = 1'b1;
                if (rd_addr_reg == '0)
                    state_next = ST_DRAIN;
                else
                    rd_addr_next = rd_addr_reg - ADDR_W'(1);
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_gain_next  = total_reg;
                    out_flag_next  = dropped_reg;
                    count_next     = '0;
                    dropped_next   = 1'b0;
                    state_next     = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            low_reg       <= '0;
            prefix_reg    <= '0;
            high_reg      <= '0;
            suffix_reg    <= '0;
            total_reg     <= '0;
            rd_addr_reg   <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_gain_reg  <= '0;
            out_flag_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            low_reg       <= low_next;
            prefix_reg    <= prefix_next;
            high_reg      <= high_next;
            suffix_reg    <= suffix_next;
            total_reg     <= total_next;
            rd_addr_reg   <= rd_addr_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
            out_gain_reg  <= out_gain_next;
            out_flag_reg  <= out_flag_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'(out_gain_reg);
    assign m_axis_tuser  = out_flag_reg;

    // Fill count never passes the store depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(SERIES_DEPTH))
        else $error("item count beyond store depth");

    // Read data is consumed only for reads issued by the walk
    a_read_origin: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> $past(state_reg == ST_WALK))
        else $error("read data without a walk read");

    // Drop flag is raised only against a full store
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dropped_reg) |-> $past(full))
        else $error("drop flagged while store had room");

    // A new result appears only when a walk completes
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("result without a finished walk");

endmodule

// ===== rtl/two_trade_max_gain_top.sv =====
// ============================================================================
// two_trade_max_gain_top
// Best total gain from at most two buy-then-sell trades over a price series.
// ============================================================================
// Stream in prices on the slave side, one word each, and mark the final price
// with tlast. Each price is written to the series store together with the
// best single-trade gain over the prefix so far. After the final word the
// block stops taking input and walks the store backward, one entry per cycle
// through the store's single read port, and then hands the total to the
// result register. The store holds 1024 prices; words past that are dropped
// and the result's overflow flag is set, with the gain taken over the stored
// part only. One result word per series leaves on the master side; loading of
// the next series may start while that word still waits.
// ============================================================================
module two_trade_max_gain_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [ttmg_pkg::IN_DATA_W-1:0]     s_axis_tdata,   // [15:0] price
    input  logic                               s_axis_tlast,   // final price of the series
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [ttmg_pkg::OUT_DATA_W-1:0]    m_axis_tdata,   // [16:0] best_gain, rest zero
    output logic                               m_axis_tuser    // [0] overflowed
);

    import ttmg_pkg::*;

    mem_wr_t mem_wr;
    mem_rd_t mem_rd;
    entry_t  mem_rdata;

    // Sequencer: load, backward walk and result register
    ttmg_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .mem_wr        (mem_wr),
        .mem_rd        (mem_rd),
        .mem_rdata     (mem_rdata)
    );

    // Series store: each entry holds {prefix gain, price}
    ttmg_ram #(
        .DATA_W (ENTRY_W),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr.en),
        .wr_addr (mem_wr.addr),
        .wr_data (mem_wr.data),
        .rd_en   (mem_rd.en),
        .rd_addr (mem_rd.addr),
        .rd_data (mem_rdata)
    );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the two-trade maximum gain block.
// ============================================================================
// Price series go in on the slave stream, one word per price, with the final
// price marked by tlast. A scoreboard keeps its own prefix store, predicts the
// best two-trade gain and the overflow flag for each series, and checks every
// result word against the oldest prediction. The run has a short directed part
// (extremes, flat, falling and classic series), then three random phases with
// different stall patterns on either side. The last random phase also carries
// one series that overflows the store, with the final price among those
// dropped. In the last phase the result side holds off for a long stretch so
// that the block backs up and stalls its input.
// ============================================================================
module tb_top;
    import ttmg_pkg::*;

    localparam int CLK_HALF_NS = 6;
    localparam int RESET_CYCLES = 9;
    localparam int CYCLE_LIMIT = 500000;
    localparam int LONG_HOLD = 2500;
    localparam int DRAIN_CYCLES = 64;

    typedef enum int unsigned {
        PRICE_FULL,
        PRICE_NARROW,
        PRICE_EXTREME
    } price_mode_e;

    // One predicted result word
    typedef struct {
        gain_t gain;
        logic  overflow;
    } series_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the series store, prediction and checking
    // ------------------------------------------------------------------------
    class gain_scoreboard;
        price_t         price_mem[SERIES_DEPTH];
        price_t         prefix_gain[SERIES_DEPTH];
        int unsigned    fill;
        price_t         run_low;
        logic           dropped;
        series_result_t pending[$];
        int unsigned    errors;

        function new();
            fill = 0;
            run_low = '0;
            dropped = 1'b0;
            errors = 0;
        endfunction

        // Best two-trade total over the stored prefix, walking backward
        function gain_t two_trade_total();
            price_t      peak;
            price_t      p;
            price_t      suffix_gain;
            gain_t       total;
            gain_t       sum;
            int unsigned j;
            if (fill == 0)
                return '0;
            peak = price_mem[fill-1];
            suffix_gain = '0;
            total = gain_t'(prefix_gain[fill-1]);
            for (j = fill - 1; j > 0; j--)
            begin
                p = price_mem[j-1];
                if (peak > p && price_t'(peak - p) > suffix_gain)
                    suffix_gain = peak - p;
                if (p > peak)
                    peak = p;
                sum = gain_t'(prefix_gain[j-1]) + gain_t'(suffix_gain);
                if (sum > total)
                    total = sum;
            end
            return total;
        endfunction

        // Take one accepted price word
        function void note_price(price_t p, logic is_final);
            price_t         g;
            series_result_t r;
            if (fill < SERIES_DEPTH)
            begin
                price_mem[fill] = p;
                if (fill == 0)
                begin
                    run_low = p;
                    prefix_gain[0] = '0;
                end
                else
                begin
                    g = prefix_gain[fill-1];
                    if (p > run_low && price_t'(p - run_low) > g)
                        g = p - run_low;
                    prefix_gain[fill] = g;
                    if (p < run_low)
                        run_low = p;
                end
                fill++;
            end
            else
                dropped = 1'b1;
            if (is_final)
            begin
                r.gain = two_trade_total();
                r.overflow = dropped;
                pending.push_back(r);
                fill = 0;
                dropped = 1'b0;
            end
        endfunction

        // Compare one accepted result word with the oldest prediction
        function void check_result(logic [OUT_DATA_W-1:0] data, logic ovf);
            series_result_t r;
            if (pending.size() == 0)
            begin
                $error("result word with no series pending: tdata=%h tuser=%b", data, ovf);
                errors++;
                return;
            end
            r = pending.pop_front();
            if (data[GAIN_W-1:0] !== r.gain)
            begin
                $error("best_gain: expected %0d, actual %0d", r.gain, data[GAIN_W-1:0]);
                errors++;
            end
            if (data[OUT_DATA_W-1:GAIN_W] !== '0)
            begin
                $error("tdata padding: expected 0, actual %h", data[OUT_DATA_W-1:GAIN_W]);
                errors++;
            end
            if (ovf !== r.overflow)
            begin
                $error("overflowed: expected %b, actual %b", r.overflow, ovf);
                errors++;
            end
        endfunction

        function int unsigned outstanding();
            return pending.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block hookup
    // ------------------------------------------------------------------------
    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata;    // [15:0] price
    logic                   s_axis_tlast;    // final price of the series
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;    // [16:0] best_gain, rest zero
    logic                   m_axis_tuser;    // [0] overflowed

    two_trade_max_gain_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    gain_scoreboard gain_sb;

    int unsigned send_idle_pct;   // chance in 100 that the sender skips a cycle
    int unsigned recv_idle_pct;   // chance in 100 that the receiver stalls
    logic        start_hold;      // ask the receiver for one long hold-off
    int unsigned cycle_count;

    // ------------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------------
    initial clk = 1'b0;
    always #(CLK_HALF_NS) clk = ~clk;

    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("two_trade_max_gain_top test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result side: random stalls, plus one long hold-off counted here
    // ------------------------------------------------------------------------
    initial
    begin : result_side
        int unsigned stall_left;
        logic        hold_done;
        stall_left = 0;
        hold_done = 1'b0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (start_hold && !hold_done)
            begin
                stall_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Check every accepted result word at the edge that takes it
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            gain_sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    // ------------------------------------------------------------------------
    // Price side
    // ------------------------------------------------------------------------

    // Offer one price word; hold it until taken, then note it
    task automatic send_word(price_t p, logic is_final);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= p;
        s_axis_tlast  <= is_final;
        do
            @(posedge clk);
        while (!s_axis_tready);
        gain_sb.note_price(p, is_final);
    endtask

    // Drop valid once a burst of words is done
    task automatic go_quiet();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
    endtask

    task automatic send_list(price_t vals[$]);
        int unsigned i;
        for (i = 0; i < vals.size(); i++)
            send_word(vals[i], i == vals.size() - 1);
    endtask

    // One series of random prices shaped by the mode
    task automatic send_series(int unsigned len, price_mode_e mode);
        int unsigned i;
        price_t      base;
        price_t      p;
        base = price_t'($urandom_range(16'hFFF0));
        for (i = 0; i < len; i++)
        begin
            case (mode)
                PRICE_NARROW:  p = base + price_t'($urandom_range(15));
                PRICE_EXTREME: p = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                default:       p = price_t'($urandom_range(16'hFFFF));
            endcase
            send_word(p, i == len - 1);
        end
    endtask

    // Mostly short series; a nonzero long_len adds one long series mid-phase
    task automatic run_random_phase(int unsigned target, int unsigned long_len);
        int unsigned sent;
        int unsigned len;
        logic        long_done;
        sent = 0;
        long_done = 1'b0;
        while (sent < target)
        begin
            if (!long_done && long_len != 0 && sent >= target / 2)
            begin
                len = long_len;
                long_done = 1'b1;
                send_series(len, PRICE_FULL);
            end
            else
            begin
                if ($urandom_range(9) == 0)
                    len = $urandom_range(60, 13);
                else
                    len = $urandom_range(12, 1);
                send_series(len, price_mode_e'($urandom_range(2)));
            end
            sent += len;
        end
        go_quiet();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_seq
        price_t vals[$];
        gain_sb = new();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        start_hold = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // Directed: single price, full-swing gain, falling, flat, rising and classic series
        send_idle_pct = 14;
        recv_idle_pct = 52;
        vals = '{16'h1234};
        send_list(vals);
        vals = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF};
        send_list(vals);
        vals = '{16'hFFFF, 16'h0000};
        send_list(vals);
        vals = '{16'h0000, 16'h0000, 16'h0000};
        send_list(vals);
        vals = '{16'd500, 16'd400, 16'd300, 16'd200};
        send_list(vals);
        vals = '{16'd10, 16'd50};
        send_list(vals);
        vals = '{16'd3, 16'd3, 16'd5, 16'd0, 16'd0, 16'd3, 16'd1, 16'd4};
        send_list(vals);
        go_quiet();

        // Sender mostly busy, receiver stalls often
        run_random_phase(60, 0);

        // Swap the stall pattern
        send_idle_pct = 52;
        recv_idle_pct = 14;
        run_random_phase(60, 0);

        // No idling; hold the result side long enough to back the block up,
        // and overflow the store with the final price dropped
        send_idle_pct = 0;
        recv_idle_pct = 0;
        start_hold = 1'b1;
        run_random_phase(100, SERIES_DEPTH + 3);

        // Let every result drain, then watch for stray words
        while (gain_sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (gain_sb.errors == 0)
            $display("two_trade_max_gain_top test passed");
        else
            $display("two_trade_max_gain_top test failed");
        $finish;
    end

endmodule

// ===== two_trade_max_gain_top.f =====
rtl/ttmg_pkg.sv
rtl/ttmg_ram.sv
rtl/ttmg_core.sv
rtl/two_trade_max_gain_top.sv
tb/tb_top.sv
